// ===== src/swfr_pkg.sv =====
// Shared types and constants for the sync word frame receiver.
// No dependencies; used by swfr_parser and sync_word_frame_receiver.

package swfr_pkg;

   // Stream and frame geometry.
   localparam int ByteWidth   = 8;
   localparam int SyncCount   = 4;
   localparam int StoreDepth  = 6;
   localparam int PosWidth    = 2 * ByteWidth;
   localparam int CsrIdxWidth = 3;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_FIRST     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_SECOND    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_THIRD     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SYNC_FOURTH    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_PAYLOAD_LENGTH = 3'd4;

   // Reset and floor value of the payload length.
   localparam logic [ByteWidth-1:0] MinPayloadLength = ByteWidth'(StoreDepth);

   // Frame phase: four header sync steps, payload, four trailer sync steps.
   typedef enum logic [8:0] {
      PH_HUNT0   = 9'b000000001,
      PH_HUNT1   = 9'b000000010,
      PH_HUNT2   = 9'b000000100,
      PH_HUNT3   = 9'b000001000,
      PH_PAYLOAD = 9'b000010000,
      PH_TRAIL0  = 9'b000100000,
      PH_TRAIL1  = 9'b001000000,
      PH_TRAIL2  = 9'b010000000,
      PH_TRAIL3  = 9'b100000000
   } phase_type;

   // Live configuration handed to the parser.
   typedef struct packed {
      logic [SyncCount-1:0][ByteWidth-1:0] sync_bytes;
      logic [ByteWidth-1:0]                payload_length;
   } cfg_type;

   // One finished frame reported by the parser.
   typedef struct packed {
      logic                valid;
      logic [PosWidth-1:0] x_position;
      logic [PosWidth-1:0] y_position;
      logic [PosWidth-1:0] z_position;
   } frame_type;

endpackage

// ===== src/swfr_parser.sv =====
// Frame parser: sync hunting, payload collection and trailer check.
// Depends on swfr_pkg for the phase encoding and the config/result structs.

module swfr_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            byte_valid,
   input  logic [swfr_pkg::ByteWidth-1:0]  rx_byte,
   input  swfr_pkg::cfg_type               cfg,
   output swfr_pkg::frame_type             frame
);

   swfr_pkg::phase_type               phase_ff, phase_in;
   logic [swfr_pkg::ByteWidth-1:0]    count_ff, count_in;
   logic [swfr_pkg::ByteWidth-1:0]    store_ff [swfr_pkg::StoreDepth];
   logic [swfr_pkg::ByteWidth-1:0]    eff_length;
   logic [swfr_pkg::ByteWidth:0]      count_next;
   logic                              store_wr;
   logic                              frame_done;

   // Lengths below the store depth behave as the store depth.
   assign eff_length = (cfg.payload_length < swfr_pkg::MinPayloadLength) ?
                       swfr_pkg::MinPayloadLength : cfg.payload_length;
   assign count_next = {1'b0, count_ff} + 9'd1;

   // Next phase and payload count for the byte in this transfer.
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      store_wr   = 1'b0;
      frame_done = 1'b0;
      if (byte_valid) begin
         case (phase_ff)
            swfr_pkg::PH_HUNT0:
               phase_in = (rx_byte == cfg.sync_bytes[0]) ? swfr_pkg::PH_HUNT1
                                                         : swfr_pkg::PH_HUNT0;
            swfr_pkg::PH_HUNT1:
               phase_in = (rx_byte == cfg.sync_bytes[1]) ? swfr_pkg::PH_HUNT2
                                                         : swfr_pkg::PH_HUNT0;
            swfr_pkg::PH_HUNT2:
               phase_in = (rx_byte == cfg.sync_bytes[2]) ? swfr_pkg::PH_HUNT3
                                                         : swfr_pkg::PH_HUNT0;
            swfr_pkg::PH_HUNT3:
               phase_in = (rx_byte == cfg.sync_bytes[3]) ? swfr_pkg::PH_PAYLOAD
                                                         : swfr_pkg::PH_HUNT0;
            swfr_pkg::PH_PAYLOAD: begin
               store_wr = 1'b1;
               if (count_next >= {1'b0, eff_length}) begin
                  count_in = '0;
                  phase_in = swfr_pkg::PH_TRAIL0;
               end else begin
                  count_in = count_next[swfr_pkg::ByteWidth-1:0];
               end
            end
            swfr_pkg::PH_TRAIL0, swfr_pkg::PH_TRAIL1,
            swfr_pkg::PH_TRAIL2, swfr_pkg::PH_TRAIL3: begin
               // A trailer mismatch drops the frame and restarts the hunt.
               if ((phase_ff == swfr_pkg::PH_TRAIL0 && rx_byte != cfg.sync_bytes[0]) ||
                   (phase_ff == swfr_pkg::PH_TRAIL1 && rx_byte != cfg.sync_bytes[1]) ||
                   (phase_ff == swfr_pkg::PH_TRAIL2 && rx_byte != cfg.sync_bytes[2]) ||
                   (phase_ff == swfr_pkg::PH_TRAIL3 && rx_byte != cfg.sync_bytes[3])) begin
                  count_in = '0;
                  phase_in = swfr_pkg::PH_HUNT0;
               end else if (phase_ff == swfr_pkg::PH_TRAIL0) begin
                  phase_in = swfr_pkg::PH_TRAIL1;
               end else if (phase_ff == swfr_pkg::PH_TRAIL1) begin
                  phase_in = swfr_pkg::PH_TRAIL2;
               end else if (phase_ff == swfr_pkg::PH_TRAIL2) begin
                  phase_in = swfr_pkg::PH_TRAIL3;
               end else begin
                  // The trailer doubles as the next header.
                  phase_in   = swfr_pkg::PH_PAYLOAD;
                  frame_done = 1'b1;
               end
            end
            default: begin
               count_in = '0;
               phase_in = swfr_pkg::PH_HUNT0;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= swfr_pkg::PH_HUNT0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Keep the first payload bytes of the frame, one entry per position.
   always_ff @(posedge clock) begin
      for (int i = 0; i < swfr_pkg::StoreDepth; i++) begin
         if (store_wr && count_ff == swfr_pkg::ByteWidth'(i)) begin
            store_ff[i] <= rx_byte;
         end
      end
   end

   // Big-endian positions from the stored bytes.
   assign frame.valid      = frame_done;
   assign frame.x_position = {store_ff[0], store_ff[1]};
   assign frame.y_position = {store_ff[2], store_ff[3]};
   assign frame.z_position = {store_ff[4], store_ff[5]};

endmodule

// ===== src/sync_word_frame_receiver.sv =====
// Top level of the sync word frame receiver: CSRs, parser and result register.
// Depends on swfr_pkg and swfr_parser.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   req_rx_byte
//   rsp      out        rsp_valid/rsp_ready   rsp_x/y/z_position
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// One byte is taken per cycle while req_ready is high; the parser state and
// the result register for a completed frame both load at the transfer edge.
// req_ready is low only while a result is held and rsp_ready is low.
// Reset is synchronous and clears phase, count, result valid and the CSRs
// (sync bytes to zero, payload length to six). CSR writes apply to the next byte.

module sync_word_frame_receiver (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [swfr_pkg::ByteWidth-1:0]     req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [swfr_pkg::PosWidth-1:0]      rsp_x_position,
   output logic [swfr_pkg::PosWidth-1:0]      rsp_y_position,
   output logic [swfr_pkg::PosWidth-1:0]      rsp_z_position,
   input  logic                               csr_write_en,
   input  logic [swfr_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [swfr_pkg::ByteWidth-1:0]     csr_wdata
);

   swfr_pkg::cfg_type              cfg_ff;
   swfr_pkg::frame_type            frame;
   logic                           req_xfer;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [swfr_pkg::PosWidth-1:0]  x_ff, y_ff, z_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_bytes     <= '0;
         cfg_ff.payload_length <= swfr_pkg::MinPayloadLength;
      end else if (csr_write_en) begin
         case (csr_index)
            swfr_pkg::CSR_SYNC_FIRST:     cfg_ff.sync_bytes[0]  <= csr_wdata;
            swfr_pkg::CSR_SYNC_SECOND:    cfg_ff.sync_bytes[1]  <= csr_wdata;
            swfr_pkg::CSR_SYNC_THIRD:     cfg_ff.sync_bytes[2]  <= csr_wdata;
            swfr_pkg::CSR_SYNC_FOURTH:    cfg_ff.sync_bytes[3]  <= csr_wdata;
            swfr_pkg::CSR_PAYLOAD_LENGTH: cfg_ff.payload_length <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input side is open whenever the result register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   swfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_xfer),
      .rx_byte    (req_rx_byte),
      .cfg        (cfg_ff),
      .frame      (frame)
   );

   // Result register valid.
   always_comb begin
      if (frame.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads with each finished frame.
   always_ff @(posedge clock) begin
      if (frame.valid) begin
         x_ff <= frame.x_position;
         y_ff <= frame.y_position;
         z_ff <= frame.z_position;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_position = x_ff;
   assign rsp_y_position = y_ff;
   assign rsp_z_position = z_ff;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for sync_word_frame_receiver: directed and random byte streams.
// Depends on swfr_pkg and the RTL of sync_word_frame_receiver; needs no other files.
// A local frame tracker predicts every position triple and a monitor checks each transfer.

module tb_top;
   import swfr_pkg::*;

   typedef struct packed {
      logic [PosWidth-1:0] x_position;
      logic [PosWidth-1:0] y_position;
      logic [PosWidth-1:0] z_position;
   } position_set_type;

   localparam int NoSlot         = -1;
   localparam int HoldoffCycles  = 300;
   localparam int DrainLimit     = 50000;
   localparam int SettleCycles   = 4;
   localparam int RandomItems    = 600;
   localparam int MaxReported    = 10;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ByteWidth-1:0]   req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PosWidth-1:0]    rsp_x_position;
   logic [PosWidth-1:0]    rsp_y_position;
   logic [PosWidth-1:0]    rsp_z_position;
   logic                   csr_write_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [ByteWidth-1:0]   csr_wdata = '0;

   // Tracker copy of the configuration and of the frame state.
   logic [ByteWidth-1:0] sync_pattern [SyncCount];
   logic [ByteWidth-1:0] rx_len;
   phase_type            rx_phase;
   logic [ByteWidth-1:0] rx_count;
   logic [ByteWidth-1:0] rx_store [StoreDepth];

   position_set_type expected_positions [$];

   int fail_count = 0;
   int items_sent = 0;
   int burst_left = 0;
   int holdoff_requests = 0;
   int holdoff_served = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int stall_age = 0;
   int stall_tick = 0;

   sync_word_frame_receiver i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_x_position (rsp_x_position),
      .rsp_y_position (rsp_y_position),
      .rsp_z_position (rsp_z_position),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // Count a failure; only the first few are printed.
   function automatic void record_failure(input string what);
      fail_count++;
      if (fail_count <= MaxReported) begin
         $display("%0t: %s", $time, what);
      end
   endfunction

   function automatic void compare_field(input string name, input logic [PosWidth-1:0] want,
                                         input logic [PosWidth-1:0] got);
      if (want !== got) begin
         record_failure($sformatf("%s mismatch: expected %04h, got %04h", name, want, got));
      end
   endfunction

   // Lengths below the store depth behave as the store depth.
   function automatic int frame_length();
      return (rx_len < MinPayloadLength) ? StoreDepth : int'(rx_len);
   endfunction

   function automatic void reset_tracker();
      for (int k = 0; k < SyncCount; k++) begin
         sync_pattern[k] = '0;
      end
      rx_len   = MinPayloadLength;
      rx_phase = PH_HUNT0;
      rx_count = '0;
      for (int k = 0; k < StoreDepth; k++) begin
         rx_store[k] = '0;
      end
   endfunction

   // Advance the frame tracker by one accepted byte; a matched trailer yields positions.
   function automatic void track_byte(input logic [ByteWidth-1:0] b);
      position_set_type frame;
      case (rx_phase)
         PH_HUNT0: rx_phase = (b == sync_pattern[0]) ? PH_HUNT1 : PH_HUNT0;
         PH_HUNT1: rx_phase = (b == sync_pattern[1]) ? PH_HUNT2 : PH_HUNT0;
         PH_HUNT2: rx_phase = (b == sync_pattern[2]) ? PH_HUNT3 : PH_HUNT0;
         PH_HUNT3: rx_phase = (b == sync_pattern[3]) ? PH_PAYLOAD : PH_HUNT0;
         PH_PAYLOAD: begin
            if (int'(rx_count) < StoreDepth) begin
               rx_store[int'(rx_count)] = b;
            end
            if (int'(rx_count) + 1 >= frame_length()) begin
               rx_count = '0;
               rx_phase = PH_TRAIL0;
            end else begin
               rx_count = rx_count + 1'b1;
            end
         end
         PH_TRAIL0, PH_TRAIL1, PH_TRAIL2, PH_TRAIL3: begin
            int slot;
            slot = (rx_phase == PH_TRAIL0) ? 0 : (rx_phase == PH_TRAIL1) ? 1 :
                   (rx_phase == PH_TRAIL2) ? 2 : 3;
            if (b != sync_pattern[slot]) begin
               // A broken trailer drops the frame and is not retried as a header byte.
               rx_count = '0;
               rx_phase = PH_HUNT0;
            end else if (rx_phase == PH_TRAIL0) begin
               rx_phase = PH_TRAIL1;
            end else if (rx_phase == PH_TRAIL1) begin
               rx_phase = PH_TRAIL2;
            end else if (rx_phase == PH_TRAIL2) begin
               rx_phase = PH_TRAIL3;
            end else begin
               // The trailer doubles as the next header.
               frame.x_position = {rx_store[0], rx_store[1]};
               frame.y_position = {rx_store[2], rx_store[3]};
               frame.z_position = {rx_store[4], rx_store[5]};
               expected_positions.push_back(frame);
               rx_phase = PH_PAYLOAD;
            end
         end
         default: rx_phase = PH_HUNT0;
      endcase
   endfunction

   // Offer one byte, hold it until the transfer, then maybe open a gap.
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      track_byte(b);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      end
   endtask

   // Send the four sync bytes, optionally with one of them corrupted.
   task automatic send_sync(input int bad_slot, input logic [ByteWidth-1:0] flip);
      for (int k = 0; k < SyncCount; k++) begin
         send_byte((k == bad_slot) ? (sync_pattern[k] ^ flip) : sync_pattern[k]);
      end
   endtask

   task automatic send_payload6(input logic [StoreDepth*ByteWidth-1:0] bytes);
      for (int k = StoreDepth - 1; k >= 0; k--) begin
         send_byte(bytes[k*ByteWidth +: ByteWidth]);
      end
   endtask

   task automatic send_random_bytes(input int count);
      repeat (count) send_byte(ByteWidth'($urandom_range(0, 255)));
   endtask

   // Stop offering, wait for every expected frame, then let the block settle.
   task automatic wait_results_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_positions.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One register write; the enable stays high for the caller to lower.
   task automatic write_register(input logic [CsrIdxWidth-1:0] idx,
                                 input logic [ByteWidth-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      case (idx)
         CSR_SYNC_FIRST:     sync_pattern[0] = value;
         CSR_SYNC_SECOND:    sync_pattern[1] = value;
         CSR_SYNC_THIRD:     sync_pattern[2] = value;
         CSR_SYNC_FOURTH:    sync_pattern[3] = value;
         CSR_PAYLOAD_LENGTH: rx_len = value;
         default: ;
      endcase
   endtask

   // Write every register; unused indexes are written too when asked and must be ignored.
   task automatic set_config(input logic [ByteWidth-1:0] s0, input logic [ByteWidth-1:0] s1,
                             input logic [ByteWidth-1:0] s2, input logic [ByteWidth-1:0] s3,
                             input logic [ByteWidth-1:0] len, input bit touch_unused);
      write_register(CSR_SYNC_FIRST, s0);
      write_register(CSR_SYNC_SECOND, s1);
      write_register(CSR_SYNC_THIRD, s2);
      write_register(CSR_SYNC_FOURTH, s3);
      write_register(CSR_PAYLOAD_LENGTH, len);
      if (touch_unused) begin
         for (int k = int'(CSR_PAYLOAD_LENGTH) + 1; k < (1 << CsrIdxWidth); k++) begin
            write_register(CsrIdxWidth'(k), ByteWidth'($urandom_range(0, 255)));
         end
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [ByteWidth-1:0] pick_sync_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return ByteWidth'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [ByteWidth-1:0] pick_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 2) begin
         return ByteWidth'($urandom_range(0, StoreDepth - 1));
      end else if (r < 16) begin
         return ByteWidth'($urandom_range(StoreDepth, 12));
      end else if (r < 19) begin
         return ByteWidth'($urandom_range(13, 40));
      end
      return ByteWidth'($urandom_range(41, 255));
   endfunction

   // Mostly well-formed frames with random content, some broken ones and some noise.
   task automatic send_traffic_unit();
      int pick;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         if (rx_phase != PH_PAYLOAD) begin
            send_sync(NoSlot, '0);
         end
         count = frame_length();
         if ($urandom_range(0, 9) == 0) begin
            count = count + $urandom_range(0, 4) - 2;
         end
         send_random_bytes(count);
         if ($urandom_range(0, 9) == 0) begin
            send_sync($urandom_range(0, SyncCount - 1), ByteWidth'($urandom_range(1, 255)));
         end else begin
            send_sync(NoSlot, '0);
         end
      end else begin
         repeat ($urandom_range(1, 6)) begin
            if (pick[0]) begin
               send_byte(sync_pattern[$urandom_range(0, SyncCount - 1)]);
            end else begin
               send_byte(ByteWidth'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Frames under the reset configuration, including two back to back.
   task automatic test_default_frames();
      send_sync(NoSlot, '0);
      send_payload6(48'hFFFF_0000_8001);
      send_sync(NoSlot, '0);
      send_payload6(48'h1234_5678_9ABC);
      send_sync(NoSlot, '0);
      wait_results_drained();
   endtask

   // Header and trailer mismatches, with writes to unused indexes and a zero length.
   task automatic test_sync_mismatch();
      set_config(8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 1'b1);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_sync(NoSlot, '0);
      send_payload6(48'h0102_0304_0506);
      send_sync(3, 8'h5A);
      send_sync(NoSlot, '0);
      send_payload6(48'h8040_2010_0804);
      send_sync(NoSlot, '0);
      wait_results_drained();
   endtask

   // Lowering the length mid-payload ends the payload on the next byte; short length acts as six.
   task automatic test_length_change();
      set_config(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'd20, 1'b0);
      send_sync(NoSlot, '0);
      send_payload6(48'hDEAD_BEEF_0F0F);
      send_random_bytes(4);
      wait_results_drained();
      set_config(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'd8, 1'b0);
      send_byte(8'h77);
      send_sync(NoSlot, '0);
      wait_results_drained();
      set_config(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'd5, 1'b0);
      send_payload6(48'h7FFF_8000_0001);
      send_sync(NoSlot, '0);
      wait_results_drained();
   endtask

   // The receiver holds off for a long stretch while frames keep coming.
   task automatic test_receiver_holdoff();
      set_config(pick_sync_byte(), pick_sync_byte(), pick_sync_byte(), pick_sync_byte(),
                 MinPayloadLength, 1'b0);
      holdoff_requests++;
      send_sync(NoSlot, '0);
      repeat (8) begin
         send_random_bytes(StoreDepth);
         send_sync(NoSlot, '0);
      end
      wait_results_drained();
   endtask

   // Random configuration phases, the extremes first, each followed by a pause.
   task automatic test_random_stream();
      int random_start;
      int phase_start;
      int phase_items;
      int phase_index;
      random_start = items_sent;
      phase_index  = 0;
      while (items_sent - random_start < RandomItems) begin
         if (phase_index == 0) begin
            set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
         end else if (phase_index == 1) begin
            set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
         end else begin
            set_config(pick_sync_byte(), pick_sync_byte(), pick_sync_byte(), pick_sync_byte(),
                       pick_length(), $urandom_range(0, 1) == 1);
         end
         phase_items = $urandom_range(60, 140);
         phase_start = items_sent;
         while (items_sent - phase_start < phase_items) begin
            send_traffic_unit();
         end
         wait_results_drained();
         phase_index++;
      end
   endtask

   // Receiver readiness: a long hold-off on request, otherwise a changing stall pattern.
   always @(posedge clock) begin
      stall_tick++;
      if (holdoff_served != holdoff_requests) begin
         holdoff_served = holdoff_requests;
         hold_left      = HoldoffCycles;
      end
      if (stall_age == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_age  = $urandom_range(20, 120);
      end else begin
         stall_age--;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= stall_tick[2];
         endcase
      end
   end

   // Check each result transfer against the oldest expected frame.
   always @(posedge clock) begin
      position_set_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_positions.size() == 0) begin
            record_failure($sformatf("unexpected frame: x %04h y %04h z %04h",
                                     rsp_x_position, rsp_y_position, rsp_z_position));
         end else begin
            want = expected_positions.pop_front();
            compare_field("x_position", want.x_position, rsp_x_position);
            compare_field("y_position", want.y_position, rsp_y_position);
            compare_field("z_position", want.z_position, rsp_z_position);
         end
      end
   end

   initial begin
      reset_tracker();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_default_frames();
      test_sync_mismatch();
      test_length_change();
      test_receiver_holdoff();
      test_random_stream();
      wait_results_drained();
      if (expected_positions.size() != 0) begin
         record_failure($sformatf("%0d expected frames never arrived",
                                  expected_positions.size()));
      end
      if (fail_count == 0) begin
         $display("sync_word_frame_receiver regression: pass");
      end else begin
         $display("sync_word_frame_receiver regression: fail");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #2000000;
      $display("sync_word_frame_receiver regression: fail");
      $finish;
   end

endmodule
